// File: src/schedule_window_relay_controller_core_macros.svh
// assertion macros for the schedule window relay controller
`ifndef SCHEDULE_WINDOW_RELAY_CONTROLLER_CORE_MACROS_SVH
`define SCHEDULE_WINDOW_RELAY_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SWRC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swrc assertion failed");
// antecedent implies consequent in the next cycle
`define SWRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swrc assertion failed");
`else
`define SWRC_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SWRC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: src/swrc_pkg.sv
// shared types and constants of the schedule window relay controller
package swrc_pkg;

  // item modes
  localparam logic [1:0] MODE_UPDATE  = 2'd0;
  localparam logic [1:0] MODE_ADVANCE = 2'd1;
  localparam logic [1:0] MODE_WINDOW  = 2'd2;

  // advance status codes
  localparam logic [1:0] ADV_SCHEDULED  = 2'd0;
  localparam logic [1:0] ADV_PLUS_HOUR  = 2'd1;
  localparam logic [1:0] ADV_NEXT_EVENT = 2'd2;
  localparam logic [1:0] ADV_RESERVED   = 2'd3;

  // appliance modes
  localparam logic [1:0] APPL_WATER_ONLY = 2'd0;
  localparam logic [1:0] APPL_WATER_HEAT = 2'd1;

  // configuration register indexes
  localparam logic CFG_APPLIANCE_MODE = 1'b0;
  localparam logic CFG_HOUR_LIMIT     = 1'b1;

  // configuration reset values
  localparam logic [1:0]  APPL_MODE_RESET  = APPL_WATER_HEAT;
  localparam logic [31:0] HOUR_LIMIT_RESET = 32'd3600000;

  // slot = hours * 10 + minutes / 10, minutes / 10 by reciprocal multiply
  localparam int         SLOT_W      = 9;
  localparam logic [7:0] DIV10_MUL   = 8'd205;
  localparam int         DIV10_SHIFT = 11;

  typedef struct packed {
    logic load;    // latch the input item, restart the scan
    logic rd_en;   // read the next window of the day
    logic commit;  // apply the item and load the result
  } swrc_cmd_t;

  typedef struct packed {
    logic scan_needed;  // update item with a day in range
    logic last_win;     // window counter is at the last window
  } swrc_status_t;

endpackage

// File: src/schedule_window_relay_controller_core.sv
// top level of the schedule window relay controller
//
// use: a weekly table of switching windows drives heating and hot water relays
// input channel (in_valid / in_stall) carries one request per item:
//   mode 0 updates the relays for day/hours/minutes, mode 1 sets the advance
//   status, mode 2 writes one window (start/end slot) of a day
// output channel (out_valid / out_stall) returns one result per request:
//   relay states, advance_changed, now_in_window and advance_now
// an update request runs a window scan that reads one table entry per cycle from
//   the single read port of the schedule memory, then a drain and a commit
// other requests, and updates for a day out of range, skip the reads and go to commit
// one request is in flight at a time; in_stall is low only while idle
// a result sits in the output register while the receiver stalls; the next
//   request is still taken and runs up to its commit, which waits there until
//   the held result is taken
// reset (rst, synchronous) empties the schedule via per-entry valid bits,
//   opens all relays, clears the advance status and restores the registers:
//   appliance_mode 1, hour_limit_ms 3600000; no clearing pass is needed
// config writes (cfg_we, cfg_index, cfg_data) are taken at once; user must write only while idle, not enforced

module schedule_window_relay_controller_core
  import swrc_pkg::*;
#(
  parameter int WINDOWS_PER_DAY_P = 4,
  parameter int DAYS_PER_WEEK     = 7
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [2:0]  day,
  input  logic [4:0]  hours,
  input  logic [5:0]  minutes,
  input  logic [31:0] elapsed_ms,
  input  logic [1:0]  advance_code,
  input  logic [1:0]  window_index,
  input  logic [7:0]  window_start,
  input  logic [7:0]  window_end,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        heating_relay,
  output logic        water_relay,
  output logic        energised,
  output logic        advance_changed,
  output logic        now_in_window,
  output logic [1:0]  advance_now
);

  // command and status between the sequencer and the datapath
  swrc_cmd_t    cmd;
  swrc_status_t status;

  // sequencer: idle, window scan, drain of the last read, commit
  swrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath: schedule memory, slot compare, advance and relay state
  swrc_datapath #(
    .WINDOWS_PER_DAY_P (WINDOWS_PER_DAY_P),
    .DAYS_PER_WEEK     (DAYS_PER_WEEK)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mode            (mode),
    .day             (day),
    .hours           (hours),
    .minutes         (minutes),
    .elapsed_ms      (elapsed_ms),
    .advance_code    (advance_code),
    .window_index    (window_index),
    .window_start    (window_start),
    .window_end      (window_end),
    .heating_relay   (heating_relay),
    .water_relay     (water_relay),
    .energised       (energised),
    .advance_changed (advance_changed),
    .now_in_window   (now_in_window),
    .advance_now     (advance_now)
  );

endmodule

// File: src/swrc_ctrl.sv
// controller state machine: sequences load, window scan and commit
`include "schedule_window_relay_controller_core_macros.svh"

module swrc_ctrl
  import swrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  output swrc_cmd_t    cmd,
  input  swrc_status_t status
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_q, state_next;
  logic       out_valid_q;
  logic       out_free;

  assign out_free  = !out_valid_q || !out_stall;
  assign in_stall  = (state_q != ST_IDLE);
  assign out_valid = out_valid_q;

  always_comb begin
    state_next = state_q;
    cmd        = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!status.scan_needed) begin
          state_next = ST_COMMIT;
        end else begin
          cmd.rd_en = 1'b1;
          if (status.last_win) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // last compare lands this cycle
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_next;
      if (cmd.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `SWRC_ASSERT_SAME(a_commit_needs_free_out, clk, rst, cmd.commit, !out_valid_q || !out_stall)
  `SWRC_ASSERT_NEXT(a_accept_starts_scan, clk, rst, in_valid && !in_stall, state_q == ST_SCAN)
  `SWRC_ASSERT_NEXT(a_drain_to_commit, clk, rst, state_q == ST_DRAIN, state_q == ST_COMMIT)

endmodule

// File: src/swrc_datapath.sv
// datapath: item latch, schedule memory, window compare, advance and relay state
`include "schedule_window_relay_controller_core_macros.svh"

module swrc_datapath
  import swrc_pkg::*;
#(
  parameter int WINDOWS_PER_DAY_P = 4,
  parameter int DAYS_PER_WEEK     = 7
) (
  input  logic         clk,
  input  logic         rst,
  input  swrc_cmd_t    cmd,
  output swrc_status_t status,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic [1:0]   mode,
  input  logic [2:0]   day,
  input  logic [4:0]   hours,
  input  logic [5:0]   minutes,
  input  logic [31:0]  elapsed_ms,
  input  logic [1:0]   advance_code,
  input  logic [1:0]   window_index,
  input  logic [7:0]   window_start,
  input  logic [7:0]   window_end,
  output logic         heating_relay,
  output logic         water_relay,
  output logic         energised,
  output logic         advance_changed,
  output logic         now_in_window,
  output logic [1:0]   advance_now
);

  localparam int ENTRIES = DAYS_PER_WEEK * WINDOWS_PER_DAY_P;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WW      = (WINDOWS_PER_DAY_P > 1) ? $clog2(WINDOWS_PER_DAY_P) : 1;

  // latched item
  logic [1:0]  mode_q;
  logic [2:0]  day_q;
  logic [4:0]  hours_q;
  logic [5:0]  minutes_q;
  logic [31:0] elapsed_q;
  logic [1:0]  code_q;
  logic [1:0]  widx_q;
  logic [7:0]  wstart_q;
  logic [7:0]  wend_q;

  // configuration
  logic [1:0]  appl_mode_q;
  logic [31:0] hour_limit_q;

  // schedule memory, start slot in the upper byte
  logic [15:0]        mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [15:0]        rd_data_q;
  logic               rd_vld_q;
  logic               cmp_pend_q;
  logic [WW-1:0]      win_q;
  logic               hit_q;

  // block state
  logic [1:0] adv_q, adv_next;
  logic       prev_q, prev_next;
  logic [2:0] relay_q, relay_next;  // heat, water, energised
  logic       changed_q, changed_next;

  logic            day_ok;
  logic            widx_ok;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  logic [13:0]     min_prod;
  logic [SLOT_W-1:0] slot;
  logic            win_match;
  logic            active;

  assign day_ok  = int'(day_q) < DAYS_PER_WEEK;
  assign widx_ok = int'(widx_q) < WINDOWS_PER_DAY_P;
  assign wr_addr = AW'(int'(day_q) * WINDOWS_PER_DAY_P + int'(widx_q));
  assign rd_addr = AW'(int'(day_q) * WINDOWS_PER_DAY_P + int'(win_q));
  assign wr_en   = cmd.commit && (mode_q == MODE_WINDOW) && day_ok && widx_ok;

  assign status.scan_needed = (mode_q == MODE_UPDATE) && day_ok;
  assign status.last_win    = (win_q == WW'(WINDOWS_PER_DAY_P - 1));

  // hours * 10 + minutes / 10, no wrap
  assign min_prod = 14'(minutes_q) * 14'(DIV10_MUL);
  assign slot     = (SLOT_W'(hours_q) << 3) + (SLOT_W'(hours_q) << 1)
                  + SLOT_W'(min_prod[DIV10_SHIFT +: 3]);

  // unwritten entries have a clear valid bit and never match
  assign win_match = rd_vld_q
                  && (slot >= SLOT_W'(rd_data_q[15:8]))
                  && (slot <  SLOT_W'(rd_data_q[7:0]));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q    <= mode;
      day_q     <= day;
      hours_q   <= hours;
      minutes_q <= minutes;
      elapsed_q <= elapsed_ms;
      code_q    <= advance_code;
      widx_q    <= window_index;
      wstart_q  <= window_start;
      wend_q    <= window_end;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wstart_q, wend_q};
    end
    if (cmd.rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_vld_q  <= valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q      <= '0;
      cmp_pend_q   <= 1'b0;
      win_q        <= '0;
      hit_q        <= 1'b0;
      appl_mode_q  <= APPL_MODE_RESET;
      hour_limit_q <= HOUR_LIMIT_RESET;
      adv_q        <= ADV_SCHEDULED;
      prev_q       <= 1'b0;
      relay_q      <= 3'b000;
      changed_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      cmp_pend_q <= cmd.rd_en;
      if (cmd.load) begin
        win_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (cmd.rd_en) begin
          win_q <= WW'(win_q + 1'b1);
        end
        if (cmp_pend_q && win_match) begin
          hit_q <= 1'b1;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_APPLIANCE_MODE: appl_mode_q  <= cfg_data[1:0];
          CFG_HOUR_LIMIT:     hour_limit_q <= cfg_data;
          default:            appl_mode_q  <= appl_mode_q;
        endcase
      end
      if (cmd.commit) begin
        adv_q     <= adv_next;
        prev_q    <= prev_next;
        relay_q   <= relay_next;
        changed_q <= changed_next;
      end
    end
  end

  always_comb begin
    adv_next     = adv_q;
    prev_next    = prev_q;
    relay_next   = relay_q;
    changed_next = 1'b0;
    active       = 1'b0;
    case (mode_q)
      MODE_UPDATE: begin
        // boundary crossing cancels any advance
        if (prev_q != hit_q) begin
          changed_next = (adv_q != ADV_SCHEDULED);
          adv_next     = ADV_SCHEDULED;
        end
        prev_next = hit_q;
        if ((adv_next == ADV_PLUS_HOUR) && (elapsed_q > hour_limit_q)) begin
          changed_next = 1'b1;
          adv_next     = ADV_SCHEDULED;
        end
        active = hit_q ^ (adv_next != ADV_SCHEDULED);
        case (appl_mode_q)
          APPL_WATER_ONLY: relay_next = {1'b0, active, active};
          APPL_WATER_HEAT: relay_next = {active, active, active};
          default:         relay_next = 3'b000;
        endcase
      end
      MODE_ADVANCE: begin
        if (code_q != ADV_RESERVED) begin
          adv_next = code_q;
        end
      end
      default: begin
        adv_next = adv_q;
      end
    endcase
  end

  assign heating_relay   = relay_q[2];
  assign water_relay     = relay_q[1];
  assign energised       = relay_q[0];
  assign advance_changed = changed_q;
  assign now_in_window   = prev_q;
  assign advance_now     = adv_q;

  `SWRC_ASSERT_SAME(a_compare_only_on_update, clk, rst, cmp_pend_q, mode_q == MODE_UPDATE && day_ok)
  `SWRC_ASSERT_SAME(a_adv_never_reserved, clk, rst, 1'b1, adv_q != ADV_RESERVED)
  `SWRC_ASSERT_SAME(a_changed_means_scheduled, clk, rst, changed_q, adv_q == ADV_SCHEDULED)

endmodule
